/* src/stp_pkg.sv */
`default_nettype none
package stp_pkg;

   typedef enum logic [1:0] {
      CMD_LOAD_B = 2'd0,
      CMD_LOAD_D = 2'd1,
      CMD_EMIT   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   localparam logic CSR_ROWS   = 1'b0;
   localparam logic CSR_STRAIN = 1'b1;

   localparam logic [5:0] ROWS_RESET   = 6'd24;
   localparam logic [2:0] STRAIN_RESET = 3'd6;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [4:0]         row;
      logic [2:0]         col;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [4:0]         out_row;
      logic [4:0]         out_col;
      logic signed [63:0] stiffness;
      logic               last;
   } rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* src/stp_store.sv */
`default_nettype none
module stp_store #(
   parameter int BA_W    = 8,
   parameter int DA_W    = 6,
   parameter int TA_W    = 3,
   parameter int B_DEPTH = 192,
   parameter int D_DEPTH = 36,
   parameter int T_DEPTH = 6
) (
   input  wire logic              clock,
   input  wire logic              b_we,
   input  wire logic [BA_W-1:0]   b_waddr,
   input  wire logic [BA_W-1:0]   b_raddr,
   input  wire logic [31:0]       b_wdata,
   output logic      [31:0]       b_rdata,
   input  wire logic              d_we,
   input  wire logic [DA_W-1:0]   d_waddr,
   input  wire logic [DA_W-1:0]   d_raddr,
   input  wire logic [31:0]       d_wdata,
   output logic      [31:0]       d_rdata,
   input  wire logic              t_we,
   input  wire logic [TA_W-1:0]   t_waddr,
   input  wire logic [TA_W-1:0]   t_raddr,
   input  wire logic [31:0]       t_wdata,
   output logic      [31:0]       t_rdata
);
   logic [31:0] b_mem [B_DEPTH];
   logic [31:0] d_mem [D_DEPTH];
   logic [31:0] t_mem [T_DEPTH];

   always_ff @(posedge clock) begin
      if (b_we) begin
         b_mem[b_waddr] <= b_wdata;
      end
      b_rdata <= b_mem[b_raddr];
   end

   always_ff @(posedge clock) begin
      if (d_we) begin
         d_mem[d_waddr] <= d_wdata;
      end
      d_rdata <= d_mem[d_raddr];
   end

   always_ff @(posedge clock) begin
      if (t_we) begin
         t_mem[t_waddr] <= t_wdata;
      end
      t_rdata <= t_mem[t_raddr];
   end
endmodule
`default_nettype wire

/* src/stiffness_triple_product_core.sv */
// channel | ports                         | handshake
// command | start, busy, req_word         | taken when start && !busy
// result  | rsp_valid, rsp_word           | one-cycle strobe, no back-pressure
// csr     | csr_we, csr_index, csr_wdata  | written when csr_we
// An emit is carried out by the single shared multiply-accumulate, fed from the B,
// D and T stores.
// Synchronous reset clears control and presets the csr registers; store contents are
// undefined until written. The receiver cannot stall; results never wait.
`default_nettype none
module stiffness_triple_product_core #(
   parameter int MAX_ROWS   = 32,
   parameter int MAX_STRAIN = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire stp_pkg::req_type req_word,
   output logic                  rsp_valid,
   output stp_pkg::rsp_type      rsp_word,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [5:0]       csr_wdata
);
   import stp_pkg::*;

   localparam int B_DEPTH  = MAX_ROWS * MAX_STRAIN;
   localparam int D_DEPTH  = MAX_STRAIN * MAX_STRAIN;
   localparam int BA_W     = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
   localparam int DA_W     = (D_DEPTH > 1) ? $clog2(D_DEPTH) : 1;
   localparam int TA_W     = (MAX_STRAIN > 1) ? $clog2(MAX_STRAIN) : 1;
   localparam int SW       = $clog2(MAX_STRAIN + 1);
   localparam int ROWS_TOP = (MAX_ROWS < 32) ? MAX_ROWS : 32;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_P1_RUN   = 7'b0000010,
      S_P1_DRAIN = 7'b0000100,
      S_P1_COEF  = 7'b0001000,
      S_P1_WRITE = 7'b0010000,
      S_P2_RUN   = 7'b0100000,
      S_P2_DRAIN = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [5:0]         rows_ff, rows_in;
   logic [2:0]         strain_ff, strain_in;
   logic [4:0]         row_ff, row_in;
   logic signed [31:0] coef_ff, coef_in;
   logic [5:0]         nr_ff, nr_in;
   logic [SW-1:0]      ns_ff, ns_in;
   logic [4:0]         j_ff, j_in;
   logic [SW-1:0]      k_ff, k_in;
   logic               v1_ff, v1_in;
   logic               v2_ff, v2_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [63:0] acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_word_ff, rsp_word_in;

   logic [5:0]         nr_eff;
   logic [SW-1:0]      ns_eff;
   logic               accept;
   logic               b_we, d_we, t_we;
   logic [BA_W-1:0]    b_waddr, b_raddr;
   logic [DA_W-1:0]    d_waddr, d_raddr;
   logic [TA_W-1:0]    t_waddr, t_raddr;
   logic [31:0]        t_wdata;
   logic [31:0]        b_rdata, d_rdata, t_rdata;
   logic signed [31:0] op_a, op_b;
   logic               k_last, j1_last, j2_last, drained;

   stp_store #(
      .BA_W(BA_W), .DA_W(DA_W), .TA_W(TA_W),
      .B_DEPTH(B_DEPTH), .D_DEPTH(D_DEPTH), .T_DEPTH(MAX_STRAIN)
   ) u_store (
      .clock(clock),
      .b_we(b_we), .b_waddr(b_waddr), .b_raddr(b_raddr),
      .b_wdata(req_word.value), .b_rdata(b_rdata),
      .d_we(d_we), .d_waddr(d_waddr), .d_raddr(d_raddr),
      .d_wdata(req_word.value), .d_rdata(d_rdata),
      .t_we(t_we), .t_waddr(t_waddr), .t_raddr(t_raddr),
      .t_wdata(t_wdata), .t_rdata(t_rdata)
   );

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      if (rows_ff == 6'd0) begin
         nr_eff = 6'd1;
      end else if (int'(rows_ff) > ROWS_TOP) begin
         nr_eff = 6'(ROWS_TOP);
      end else begin
         nr_eff = rows_ff;
      end
      if (strain_ff == 3'd0) begin
         ns_eff = SW'(1);
      end else if (int'(strain_ff) > MAX_STRAIN) begin
         ns_eff = SW'(MAX_STRAIN);
      end else begin
         ns_eff = SW'(strain_ff);
      end
   end

   // loads
   assign b_we = accept && (req_word.cmd == CMD_LOAD_B) &&
                 (int'(req_word.row) < MAX_ROWS) && (int'(req_word.col) < MAX_STRAIN);
   assign d_we = accept && (req_word.cmd == CMD_LOAD_D) &&
                 (int'(req_word.row) < MAX_STRAIN) && (int'(req_word.col) < MAX_STRAIN);
   assign b_waddr = BA_W'(int'(req_word.row) * MAX_STRAIN + int'(req_word.col));
   assign d_waddr = DA_W'(int'(req_word.row) * MAX_STRAIN + int'(req_word.col));

   // read addresses
   always_comb begin
      if (state_ff == S_P2_RUN) begin
         b_raddr = BA_W'(int'(j_ff) * MAX_STRAIN + int'(k_ff));
      end else begin
         b_raddr = BA_W'(int'(row_ff) * MAX_STRAIN + int'(k_ff));
      end
      d_raddr = DA_W'(int'(j_ff) * MAX_STRAIN + int'(k_ff));
      t_raddr = TA_W'(k_ff);
   end

   assign t_we    = (state_ff == S_P1_WRITE);
   assign t_waddr = TA_W'(j_ff);
   assign t_wdata = sat32(prod_ff >>> 16);

   assign k_last  = (int'(k_ff) + 1 == int'(ns_ff));
   assign j1_last = (int'(j_ff) + 1 == int'(ns_ff));
   assign j2_last = (int'(j_ff) + 1 == int'(nr_ff));
   assign drained = !v1_ff && !v2_ff;

   // shared multiplier operands
   always_comb begin
      priority if (state_ff == S_P1_COEF) begin
         op_a = coef_ff;
         op_b = sat32(acc_ff);
      end else if (state_ff == S_P1_RUN || state_ff == S_P1_DRAIN) begin
         op_a = b_rdata;
         op_b = d_rdata;
      end else begin
         op_a = t_rdata;
         op_b = b_rdata;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rows_in      = rows_ff;
      strain_in    = strain_ff;
      row_in       = row_ff;
      coef_in      = coef_ff;
      nr_in        = nr_ff;
      ns_in        = ns_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      v1_in        = 1'b0;
      v2_in        = v1_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS:   rows_in   = csr_wdata;
            CSR_STRAIN: strain_in = csr_wdata[2:0];
            default:    ;
         endcase
      end

      if (v1_ff || state_ff == S_P1_COEF) begin
         prod_in = op_a * op_b;
      end
      if (v2_ff) begin
         acc_in = acc_ff + (prod_ff >>> 16);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_word.cmd == CMD_EMIT && {1'b0, req_word.row} < nr_eff) begin
               row_in   = req_word.row;
               coef_in  = req_word.value;
               nr_in    = nr_eff;
               ns_in    = ns_eff;
               j_in     = 5'd0;
               k_in     = '0;
               state_in = S_P1_RUN;
            end
         end
         S_P1_RUN, S_P2_RUN: begin
            if (k_ff == '0) begin
               acc_in = '0;
            end
            v1_in = 1'b1;
            if (k_last) begin
               k_in     = '0;
               state_in = (state_ff == S_P1_RUN) ? S_P1_DRAIN : S_P2_DRAIN;
            end else begin
               k_in = SW'(k_ff + SW'(1));
            end
         end
         S_P1_DRAIN: begin
            if (drained) begin
               state_in = S_P1_COEF;
            end
         end
         S_P1_COEF: begin
            state_in = S_P1_WRITE;
         end
         S_P1_WRITE: begin
            if (j1_last) begin
               j_in     = 5'd0;
               state_in = S_P2_RUN;
            end else begin
               j_in     = j_ff + 5'd1;
               state_in = S_P1_RUN;
            end
         end
         S_P2_DRAIN: begin
            if (drained) begin
               rsp_valid_in          = 1'b1;
               rsp_word_in.out_row   = row_ff;
               rsp_word_in.out_col   = j_ff;
               rsp_word_in.stiffness = acc_ff;
               rsp_word_in.last      = j2_last;
               if (j2_last) begin
                  state_in = S_IDLE;
               end else begin
                  j_in     = j_ff + 5'd1;
                  state_in = S_P2_RUN;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rows_ff      <= ROWS_RESET;
         strain_ff    <= STRAIN_RESET;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         j_ff         <= 5'd0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         strain_ff    <= strain_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      coef_ff     <= coef_in;
      nr_ff       <= nr_in;
      ns_ff       <= ns_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_word_ff <= rsp_word_in;
   end
endmodule
`default_nettype wire
